### design/ritoa_pkg.sv
`default_nettype none

package ritoa_pkg;

    localparam logic [5:0] RADIX_MIN   = 6'd2;
    localparam logic [5:0] RADIX_MAX   = 6'd36;
    localparam logic [5:0] RADIX_RESET = 6'd10;
    localparam logic [5:0] TEN_DIGIT   = 6'h0A;
    localparam logic [5:0] NINE_DIGIT  = 6'd9;
    localparam logic [6:0] ASCII_ZERO  = 7'h30;
    localparam logic [6:0] ASCII_A     = 7'h41;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_STORE,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic store;
        logic rd;
        logic emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_last;
        logic q_zero;
        logic cnt_full;
        logic cnt_one;
        logic out_free;
    } t_status;

    function automatic logic [5:0] clamp_radix(input logic [5:0] r);
        logic [5:0] res;
        res = r;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    function automatic logic [6:0] digit_to_ascii(input logic [5:0] d);
        logic [6:0] res;
        if (d <= NINE_DIGIT) begin
            res = {1'b0, d} + ASCII_ZERO;
        end else begin
            res = {1'b0, d - TEN_DIGIT} + ASCII_A;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### design/radix_integer_to_ascii.sv
`default_nettype none
// Converts one value per input transfer into ASCII digits, most significant first.
// Each digit comes from the bit-serial restoring radix divider and is written to the
// digit store; each character is read from the store and loaded into the output register,
// which waits while the output is stalled. A new value is accepted only once the last
// character of the previous item has been loaded into the output register.
// Synchronous active-low reset clears control state and sets radix 10; store not cleared.

module radix_integer_to_ascii #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 32
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [5:0]                         i_cfg_data,      // radix
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire  [((VALUE_WIDTH+7)/8)*8-1:0]   i_s_axis_tdata,  // value
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    output logic [7:0]                         o_m_axis_tdata,  // ascii_char, zero pad
    output logic                               o_m_axis_tlast   // last_digit
);

    ritoa_pkg::t_cmd    cmd;
    ritoa_pkg::t_status status;
    logic [6:0]         out_char;

    assign o_cfg_ready = 1'b1;

    ritoa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ritoa_dp #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_value     (i_s_axis_tdata[VALUE_WIDTH-1:0]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_char  (out_char),
        .o_out_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, out_char};

endmodule

`default_nettype wire

### design/ritoa_ctrl.sv
`default_nettype none

module ritoa_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  ritoa_pkg::t_status   i_status,
    output ritoa_pkg::t_cmd      o_cmd
);

    ritoa_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ritoa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ritoa_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = ritoa_pkg::ST_DIV;
            end
            ritoa_pkg::ST_DIV: begin
                if (i_status.div_last) n_state = ritoa_pkg::ST_STORE;
            end
            ritoa_pkg::ST_STORE: begin
                if (!i_status.q_zero && !i_status.cnt_full) begin
                    n_state = ritoa_pkg::ST_DIV;
                end else begin
                    n_state = ritoa_pkg::ST_EMIT_RD;
                end
            end
            ritoa_pkg::ST_EMIT_RD: begin
                n_state = ritoa_pkg::ST_EMIT_LD;
            end
            ritoa_pkg::ST_EMIT_LD: begin
                if (i_status.out_free) begin
                    n_state = i_status.cnt_one ? ritoa_pkg::ST_IDLE : ritoa_pkg::ST_EMIT_RD;
                end
            end
            default: n_state = ritoa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ritoa_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ritoa_pkg::ST_DIV:     o_cmd.div_step = 1'b1;
            ritoa_pkg::ST_STORE:   o_cmd.store    = 1'b1;
            ritoa_pkg::ST_EMIT_RD: o_cmd.rd       = 1'b1;
            ritoa_pkg::ST_EMIT_LD: o_cmd.emit     = i_status.out_free;
            default: begin
                o_in_ready = 1'b0;
                o_cmd      = '0;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_at_most_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("ritoa_ctrl: more than one datapath command");
`endif

endmodule

`default_nettype wire

### design/ritoa_dp.sv
`default_nettype none

module ritoa_dp #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 32
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  ritoa_pkg::t_cmd         i_cmd,
    output ritoa_pkg::t_status      o_status,
    input  wire [VALUE_WIDTH-1:0]   i_value,
    input  wire                     i_cfg_valid,
    input  wire [5:0]               i_cfg_data,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output logic [6:0]              o_out_char,
    output logic                    o_out_last
);

    localparam int BW = $clog2(VALUE_WIDTH);
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int AW = $clog2(MAX_DIGITS);

    logic [5:0]             r_radix;
    logic [VALUE_WIDTH-1:0] r_dvd;
    logic [5:0]             r_rem;
    logic [BW-1:0]          r_bit;
    logic [CW-1:0]          r_cnt;
    logic [6:0]             r_mem [MAX_DIGITS];
    logic [6:0]             r_rd_data;
    logic                   r_out_valid;
    logic [6:0]             r_out_char;
    logic                   r_out_last;

    logic [6:0]    n_trial;
    logic          n_qbit;
    logic [6:0]    n_diff;
    logic [CW-1:0] n_rd_idx;

    // one restoring division step: shift in the next dividend bit, try to subtract
    always_comb begin
        n_trial = {r_rem, r_dvd[VALUE_WIDTH-1]};
        n_diff  = n_trial - {1'b0, r_radix};
        n_qbit  = (n_trial >= {1'b0, r_radix});
    end

    assign n_rd_idx = r_cnt - CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= ritoa_pkg::RADIX_RESET;
        end else if (i_cfg_valid) begin
            r_radix <= ritoa_pkg::clamp_radix(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvd <= '0;
            r_rem <= '0;
            r_bit <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.load) begin
                r_dvd <= i_value;
                r_rem <= '0;
                r_bit <= '0;
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_dvd <= {r_dvd[VALUE_WIDTH-2:0], n_qbit};
                r_rem <= n_qbit ? n_diff[5:0] : n_trial[5:0];
                r_bit <= r_bit + BW'(1);
            end else if (i_cmd.store) begin
                r_rem <= '0;
                r_bit <= '0;
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.emit) begin
                r_cnt <= n_rd_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_cnt[AW-1:0]] <= ritoa_pkg::digit_to_ascii(r_rem);
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[n_rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_char <= r_rd_data;
            r_out_last <= (r_cnt == CW'(1));
        end
    end

    always_comb begin
        o_status.div_last = (r_bit == BW'(VALUE_WIDTH - 1));
        o_status.q_zero   = (r_dvd == '0);
        o_status.cnt_full = (r_cnt == CW'(MAX_DIGITS - 1));
        o_status.cnt_one  = (r_cnt == CW'(1));
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

`ifndef NO_ASSERTIONS
    a_store_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |-> (r_cnt < CW'(MAX_DIGITS)))
        else $error("ritoa_dp: digit store overflow");
    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd || i_cmd.emit) |-> (r_cnt != '0))
        else $error("ritoa_dp: read from empty digit store");
    a_emit_not_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("ritoa_dp: output register overwritten before transfer");
    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.div_step) |-> (r_rem < r_radix))
        else $error("ritoa_dp: partial remainder not below radix");
`endif

endmodule

`default_nettype wire
